FILE: hw/rtl/nfa_pkg.sv
// Shared types and constants for the next-fit identifier allocator.
// Holds the bitmap word geometry, the status codes and the sequencer states.
// No dependencies.
package nfa_pkg;

    // Bitmap word geometry: one memory word holds this many map entries.
    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;

    // Result status codes.
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_FULL        = 2'd1;
    localparam logic [1:0] ST_BAD_RELEASE = 2'd2;

    // Request kinds as carried on the mode input.
    typedef enum logic {
        MODE_ALLOC   = 1'b0,
        MODE_RELEASE = 1'b1
    } mode_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL
    } state_t;

endpackage

FILE: hw/rtl/nfa_map_ram.sv
// Single-port-write, single-port-read bitmap memory with registered read data.
// Uses nfa_pkg for the word width.
module nfa_map_ram #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [ADDR_W-1:0]         waddr,
    input  logic [nfa_pkg::WORD_W-1:0] wdata,
    input  logic [ADDR_W-1:0]         raddr,
    output logic [nfa_pkg::WORD_W-1:0] rdata
);
    import nfa_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/next_fit_id_allocator_unit.sv
// An allocate passes from accept through a read and an evaluate state for each of the k
// 32-entry bitmap words the next-fit scan reads (1 to ceil(NUM_IDS/32) + 1); a release reads
// and evaluates one word; an allocate when full or an out-of-range release is answered from
// the idle state. busy falls in the cycle the strobe shows, so the next request may start
// then. After reset, busy stays high while a clearing pass zeroes the bitmap memory; the
// receiver cannot stall.
module next_fit_id_allocator_unit #(
    parameter int NUM_IDS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [15:0] release_id,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output logic        result_valid,
    output logic [15:0] given_id,
    output logic [1:0]  status,
    output logic [12:0] used_count
);
    import nfa_pkg::*;

    localparam int NUM_WORDS = (NUM_IDS + WORD_W - 1) / WORD_W;
    localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int PAD_W     = ADDR_W + BIT_W;
    localparam int IDX_W     = $clog2(NUM_IDS);
    localparam int CNT_W     = $clog2(NUM_IDS + 1);
    localparam int LAST_BITS = NUM_IDS - (NUM_WORDS - 1) * WORD_W;

    localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(NUM_WORDS - 1);
    localparam logic [16:0]       ID_LIMIT  = 17'(NUM_IDS);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(NUM_IDS);
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(NUM_IDS - 1);

    state_t state_reg, state_next;

    logic [15:0]        base_reg;
    logic [IDX_W-1:0]   ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [ADDR_W-1:0]  word_reg;
    logic [BIT_W-1:0]   bit_reg;
    logic               first_reg;
    logic               mode_reg;
    logic               res_valid_reg;
    logic [15:0]        res_id_reg;
    logic [1:0]         res_status_reg;

    logic               ram_we;
    logic [WORD_W-1:0]  ram_wdata;
    logic [WORD_W-1:0]  rd_word;

    logic [15:0]        rel_off;
    logic               rel_in_range;
    logic [PAD_W-1:0]   rel_pad;
    logic [PAD_W-1:0]   ptr_pad;
    logic               accept;
    logic               req_full;
    logic               req_bad;

    logic [WORD_W-1:0]  valid_mask;
    logic [WORD_W-1:0]  start_mask;
    logic [WORD_W-1:0]  free_bits;
    logic               found;
    logic [BIT_W-1:0]   enc;
    logic [PAD_W-1:0]   hit_pad;
    logic [IDX_W-1:0]   hit_idx;
    logic [WORD_W-1:0]  alloc_bit;
    logic [WORD_W-1:0]  rel_bit;
    logic               rel_hit;
    logic [CNT_W+12:0]  count_ext;

    // Bitmap storage, one bit per identifier.
    nfa_map_ram #(
        .DEPTH  (NUM_WORDS),
        .ADDR_W (ADDR_W)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (word_reg),
        .wdata (ram_wdata),
        .raddr (word_reg),
        .rdata (rd_word)
    );

    // Request decode at the accepting edge.
    assign accept       = start && (state_reg == S_IDLE);
    assign rel_off      = release_id - base_reg;
    assign rel_in_range = ({1'b0, rel_off} < ID_LIMIT);
    assign rel_pad      = PAD_W'(rel_off);
    assign ptr_pad      = PAD_W'(ptr_reg);
    assign req_full     = (mode == MODE_ALLOC) && (count_reg == CNT_FULL);
    assign req_bad      = (mode == MODE_RELEASE) && !rel_in_range;

    // Free-entry search inside the word just read.
    always_comb
    begin
        for (int i = 0; i < WORD_W; i++)
        begin
            valid_mask[i] = (word_reg != LAST_WORD) || (i < LAST_BITS);
        end
        start_mask = first_reg ? ({WORD_W{1'b1}} << bit_reg) : {WORD_W{1'b1}};
        free_bits  = ~rd_word & valid_mask & start_mask;
        found      = |free_bits;
        enc        = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                enc = BIT_W'(i);
            end
        end
    end

    assign hit_pad   = {word_reg, enc};
    assign hit_idx   = IDX_W'(hit_pad);
    assign alloc_bit = WORD_W'(1) << enc;
    assign rel_bit   = WORD_W'(1) << bit_reg;
    assign rel_hit   = rd_word[bit_reg];

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (word_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept && !req_full && !req_bad)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if ((mode_reg == MODE_RELEASE) || found)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory write controls: zero fill during the clearing pass, write-back on evaluate.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
            end
            S_EVAL:
            begin
                if (mode_reg == MODE_RELEASE)
                begin
                    ram_we    = rel_hit;
                    ram_wdata = rd_word & ~rel_bit;
                end
                else
                begin
                    ram_we    = found;
                    ram_wdata = rd_word | alloc_bit;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= 16'd300;
        end
        else if (cfg_valid && cfg_ready)
        begin
            base_reg <= cfg_data;
        end
    end

    // Request tracking, scan position, allocator state and result beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg        <= '0;
            count_reg      <= '0;
            word_reg       <= '0;
            bit_reg        <= '0;
            first_reg      <= 1'b0;
            mode_reg       <= 1'b0;
            res_valid_reg  <= 1'b0;
            res_id_reg     <= '0;
            res_status_reg <= ST_OK;
        end
        else
        begin
            res_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    word_reg <= (word_reg == LAST_WORD) ? '0 : word_reg + 1'b1;
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        mode_reg <= mode;
                        if (req_full || req_bad)
                        begin
                            res_valid_reg  <= 1'b1;
                            res_id_reg     <= '0;
                            res_status_reg <= req_full ? ST_FULL : ST_BAD_RELEASE;
                        end
                        else if (mode == MODE_ALLOC)
                        begin
                            word_reg  <= ptr_pad[PAD_W-1:BIT_W];
                            bit_reg   <= ptr_pad[BIT_W-1:0];
                            first_reg <= 1'b1;
                        end
                        else
                        begin
                            word_reg <= rel_pad[PAD_W-1:BIT_W];
                            bit_reg  <= rel_pad[BIT_W-1:0];
                        end
                    end
                end
                S_READ:
                begin
                    word_reg <= word_reg;
                end
                S_EVAL:
                begin
                    if (mode_reg == MODE_RELEASE)
                    begin
                        res_valid_reg <= 1'b1;
                        res_id_reg    <= '0;
                        if (rel_hit)
                        begin
                            count_reg      <= count_reg - 1'b1;
                            res_status_reg <= ST_OK;
                        end
                        else
                        begin
                            res_status_reg <= ST_BAD_RELEASE;
                        end
                    end
                    else if (found)
                    begin
                        count_reg      <= count_reg + 1'b1;
                        ptr_reg        <= (hit_idx == IDX_LAST) ? '0 : hit_idx + 1'b1;
                        res_valid_reg  <= 1'b1;
                        res_id_reg     <= base_reg + 16'(hit_pad);
                        res_status_reg <= ST_OK;
                    end
                    else
                    begin
                        // Nothing free here: move on to the next word, wrapping.
                        word_reg  <= (word_reg == LAST_WORD) ? '0 : word_reg + 1'b1;
                        first_reg <= 1'b0;
                    end
                end
                default:
                begin
                    res_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    // Port drive. The in-use count is shown at all times, masked to the port width.
    // The base is taken only while idle and no request is offered, so a request in
    // flight always sees one base from accept to result.
    assign count_ext    = (CNT_W + 13)'(count_reg);
    assign used_count   = count_ext[12:0];
    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = (state_reg == S_IDLE) && !start;
    assign result_valid = res_valid_reg;
    assign given_id     = res_id_reg;
    assign status       = res_status_reg;

endmodule

FILE: hw/rtl/nfa_checker.sv
// Port-level checks for the next-fit identifier allocator, bound to the top level.
// Depends on nfa_pkg for the status codes.
module nfa_checker #(
    parameter int NUM_IDS = 4096
) (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        mode,
    input logic [15:0] release_id,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [15:0] cfg_data,
    input logic        result_valid,
    input logic [15:0] given_id,
    input logic [1:0]  status,
    input logic [12:0] used_count
);
    import nfa_pkg::*;

    localparam logic [12:0] FULL_COUNT = 13'(NUM_IDS);

    // An accepted request either answers at once or keeps the unit busy.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || result_valid))
        else $error("accepted request neither answered nor held busy");

    // Only defined status codes are reported.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (status == ST_OK || status == ST_FULL || status == ST_BAD_RELEASE))
        else $error("undefined status code on result beat");

    // A failed request returns a zero identifier.
    a_fail_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status != ST_OK) |-> (given_id == 16'd0))
        else $error("nonzero identifier on failed request");

    // A full report means every identifier is in use.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == ST_FULL) |-> (used_count == FULL_COUNT))
        else $error("full status while identifiers remain free");

    // A rejected release leaves the in-use count alone.
    a_bad_release_count: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == ST_BAD_RELEASE) |-> $stable(used_count))
        else $error("in-use count moved on rejected release");

endmodule

bind next_fit_id_allocator_unit nfa_checker #(.NUM_IDS(NUM_IDS)) u_nfa_checker (.*);

FILE: test/nfa_result_checker.sv
// Result checker for the next-fit identifier allocator: watches the request, base-write
// and result channels, predicts every result and compares it field by field.
// Depends on nfa_pkg for the request kinds and status codes.
`timescale 1ns / 100ps

module nfa_result_checker #(
    parameter int NUM_IDS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        mode,
    input  logic [15:0] release_id,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        result_valid,
    input  logic [15:0] given_id,
    input  logic [1:0]  status,
    input  logic [12:0] used_count,
    output int          n_errors,
    output int          n_outstanding
);
    import nfa_pkg::*;

    typedef struct packed {
        logic [15:0] given;
        logic [1:0]  status;
        logic [12:0] count;
    } alloc_answer_t;

    // Shadow copy of the allocator state.
    bit            entry_used [NUM_IDS];
    int unsigned   scan_ptr;
    int unsigned   live_total;
    logic [15:0]   id_base;

    alloc_answer_t expected_answers [$];
    alloc_answer_t want;
    int            err_count = 0;

    task automatic log_mismatch(input string what);
        err_count++;
        if (err_count <= 10)
        begin
            $display("%0t: mismatch: %s", $time, what);
        end
    endtask

    // Works out the answer to one request and updates the shadow state.
    function automatic alloc_answer_t answer_request(input mode_t kind, input logic [15:0] rid);
        alloc_answer_t ans;
        int unsigned   pos;
        bit            found;
        logic [15:0]   offset;
        ans = '0;
        ans.status = ST_OK;
        if (kind == MODE_ALLOC)
        begin
            found = 1'b0;
            pos = scan_ptr;
            if (live_total < NUM_IDS)
            begin
                for (int n = 0; n < NUM_IDS && !found; n++)
                begin
                    if (!entry_used[pos])
                        found = 1'b1;
                    else
                        pos = (pos + 1) % NUM_IDS;
                end
            end
            if (found)
            begin
                entry_used[pos] = 1'b1;
                live_total++;
                scan_ptr = (pos + 1) % NUM_IDS;
                ans.given = id_base + 16'(pos);
            end
            else
            begin
                ans.status = ST_FULL;
            end
        end
        else
        begin
            // The identifier maps back to an entry modulo 65536.
            offset = rid - id_base;
            if (offset < NUM_IDS && entry_used[offset])
            begin
                entry_used[offset] = 1'b0;
                if (live_total > 0)
                    live_total--;
            end
            else
            begin
                ans.status = ST_BAD_RELEASE;
            end
        end
        ans.count = 13'(live_total);
        return ans;
    endfunction

    // Compare results first, then take the base write and the new request of this edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_IDS; i++)
                entry_used[i] = 1'b0;
            scan_ptr = 0;
            live_total = 0;
            id_base = 16'd300;
            expected_answers.delete();
            n_outstanding <= 0;
            n_errors <= err_count;
        end
        else
        begin
            if (result_valid)
            begin
                if (expected_answers.size() == 0)
                begin
                    log_mismatch($sformatf("result with nothing outstanding: %0d %0d %0d",
                                           given_id, status, used_count));
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (given_id !== want.given)
                        log_mismatch($sformatf("given_id expected %0d, got %0d",
                                               want.given, given_id));
                    if (status !== want.status)
                        log_mismatch($sformatf("status expected %0d, got %0d",
                                               want.status, status));
                    if (used_count !== want.count)
                        log_mismatch($sformatf("used_count expected %0d, got %0d",
                                               want.count, used_count));
                end
            end
            if (cfg_valid && cfg_ready)
                id_base = cfg_data;
            if (start && !busy)
                expected_answers.push_back(answer_request(mode_t'(mode), release_id));
            n_outstanding <= expected_answers.size();
            n_errors <= err_count;
        end
    end

endmodule

FILE: test/tb_next_fit_id_allocator_unit.sv
// Testbench top for the next-fit identifier allocator: drives requests and base writes,
// follows the handed-out identifiers to build valid releases, and gives the verdict.
// Depends on nfa_pkg, next_fit_id_allocator_unit and nfa_result_checker.
`timescale 1ns / 100ps

module tb_next_fit_id_allocator_unit;
    import nfa_pkg::*;

    localparam int NUM_IDS = 4096;

    typedef struct {
        mode_t       kind;
        logic [15:0] rid;
    } issued_req_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    mode_t       mode;
    logic [15:0] release_id;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        result_valid;
    logic [15:0] given_id;
    logic [1:0]  status;
    logic [12:0] used_count;
    int          mismatch_total;
    int          outstanding;

    // Stimulus bookkeeping: requests in flight and entries known to be in use.
    issued_req_t issued_reqs [$];
    issued_req_t done_req;
    int          live_entries [$];
    logic [15:0] cur_base = 16'd300;
    int          n_sent = 0;
    int          n_bases = 0;
    int          n_given = 0;
    int          n_freed = 0;
    int          n_full = 0;
    int          n_rejected = 0;

    next_fit_id_allocator_unit #(
        .NUM_IDS(NUM_IDS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mode(mode),
        .release_id(release_id),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .result_valid(result_valid),
        .given_id(given_id),
        .status(status),
        .used_count(used_count)
    );

    nfa_result_checker #(
        .NUM_IDS(NUM_IDS)
    ) result_chk (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mode(mode),
        .release_id(release_id),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .result_valid(result_valid),
        .given_id(given_id),
        .status(status),
        .used_count(used_count),
        .n_errors(mismatch_total),
        .n_outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int entry_of(input logic [15:0] id);
        logic [15:0] offset;
        offset = id - cur_base;
        return int'(offset);
    endfunction

    function automatic void drop_live(input int entry);
        for (int i = 0; i < live_entries.size(); i++)
        begin
            if (live_entries[i] == entry)
            begin
                live_entries.delete(i);
                return;
            end
        end
    endfunction

    // Follow the results to learn which entries are in use.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && issued_reqs.size() != 0)
        begin
            done_req = issued_reqs.pop_front();
            if (status == ST_FULL)
                n_full++;
            else if (status == ST_BAD_RELEASE)
                n_rejected++;
            else if (done_req.kind == MODE_ALLOC)
            begin
                n_given++;
                live_entries.push_back(entry_of(given_id));
            end
            else
            begin
                n_freed++;
                drop_live(entry_of(done_req.rid));
            end
        end
    end

    // One request beat, with an occasional gap before it.
    task automatic send_item(input mode_t kind, input logic [15:0] rid, input bit may_idle);
        if (may_idle && $urandom_range(0, 99) < 11)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start <= 1'b1;
        mode <= kind;
        release_id <= rid;
        do @(posedge clk); while (busy);
        issued_reqs.push_back('{kind, rid});
        n_sent++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_base(input logic [15:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_base = value;
        n_bases++;
    endtask

    // Random mix of allocations and releases: the releases are mostly of live identifiers, some of free or stray ones.
    task automatic run_mix(input int items, input int alloc_pct, input bit may_idle);
        logic [15:0] rid;
        int          pick;
        for (int i = 0; i < items; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < alloc_pct)
            begin
                send_item(MODE_ALLOC, 16'($urandom()), may_idle);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75 && live_entries.size() != 0)
                    rid = cur_base
                          + 16'(live_entries[$urandom_range(0, live_entries.size() - 1)]);
                else if (pick < 87)
                    rid = cur_base + 16'($urandom_range(0, NUM_IDS - 1));
                else
                    rid = 16'($urandom());
                send_item(MODE_RELEASE, rid, may_idle);
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        mode <= MODE_ALLOC;
        release_id <= 16'd0;
        cfg_valid <= 1'b0;
        cfg_data <= 16'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset base, first allocations, every kind of bad release.
        send_item(MODE_ALLOC, 16'd0, 1'b1);
        send_item(MODE_ALLOC, 16'hFFFF, 1'b1);
        send_item(MODE_ALLOC, 16'd0, 1'b1);
        send_item(MODE_RELEASE, cur_base + 16'd1, 1'b1);
        send_item(MODE_RELEASE, cur_base + 16'd1, 1'b1);
        send_item(MODE_RELEASE, cur_base - 16'd1, 1'b1);
        send_item(MODE_RELEASE, cur_base + 16'(NUM_IDS), 1'b1);
        send_item(MODE_RELEASE, cur_base + 16'(NUM_IDS - 1), 1'b1);
        send_item(MODE_RELEASE, 16'hFFFF, 1'b1);
        send_item(MODE_RELEASE, 16'd0, 1'b1);
        send_item(MODE_ALLOC, 16'd0, 1'b1);

        // Base moved while identifiers are in use: releases map through the new base.
        write_base(16'd0);
        send_item(MODE_RELEASE, 16'd300, 1'b1);
        send_item(MODE_RELEASE, 16'd0, 1'b1);
        send_item(MODE_ALLOC, 16'd0, 1'b1);

        // Highest base: the last entry maps to the top identifier.
        write_base(16'd61440);
        send_item(MODE_RELEASE, 16'd61442, 1'b1);
        send_item(MODE_RELEASE, 16'hFFFF, 1'b1);
        send_item(MODE_RELEASE, 16'd61439, 1'b1);
        send_item(MODE_ALLOC, 16'd0, 1'b1);

        // Random phases over several bases.
        write_base(16'($urandom_range(0, 61440)));
        run_mix(250, 70, 1'b1);
        write_base(16'd0);
        run_mix(250, 55, 1'b0);

        // Highest base again, then churn with an even mix and one that leans toward releases.
        write_base(16'd61440);
        run_mix(300, 50, 1'b1);
        run_mix(200, 30, 1'b1);

        write_base(16'($urandom_range(0, 61440)));
        run_mix(250, 45, 1'b1);
        write_base(16'd300);
        run_mix(250, 60, 1'b1);

        wait_idle();
        repeat (300) @(posedge clk);

        $display("Sent %0d requests under %0d base settings over a map of %0d entries.",
                 n_sent, n_bases, NUM_IDS);
        $display("Handed out %0d ids, freed %0d, answered full %0d times, rejected %0d releases.",
                 n_given, n_freed, n_full, n_rejected);
        if (mismatch_total == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
